@@ design/assert_macros.svh @@
// assertion macros used by the execute core
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define C8_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define C8_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define C8_ASSERT(lbl, clk, rst_n, prop, msg)
`define C8_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

@@ design/c8alu_pkg.sv @@
// types and constants of the 8-bit execute unit
// no dependencies
package c8alu_pkg;

  typedef enum logic [5:0] {
    OP_LDA = 6'd0,  OP_LDX = 6'd1,  OP_LDY = 6'd2,  OP_TAX = 6'd3,
    OP_TAY = 6'd4,  OP_TXA = 6'd5,  OP_TYA = 6'd6,  OP_TSX = 6'd7,
    OP_TXS = 6'd8,  OP_AND = 6'd9,  OP_EOR = 6'd10, OP_ORA = 6'd11,
    OP_BIT = 6'd12, OP_ADC = 6'd13, OP_SBC = 6'd14, OP_CMP = 6'd15,
    OP_CPX = 6'd16, OP_CPY = 6'd17, OP_STA = 6'd18, OP_STX = 6'd19,
    OP_STY = 6'd20, OP_INC = 6'd21, OP_INX = 6'd22, OP_INY = 6'd23,
    OP_DEC = 6'd24, OP_DEX = 6'd25, OP_DEY = 6'd26, OP_ASL = 6'd27,
    OP_LSR = 6'd28, OP_ROL = 6'd29, OP_ROR = 6'd30, OP_CLC = 6'd31,
    OP_CLD = 6'd32, OP_CLI = 6'd33, OP_CLV = 6'd34, OP_SEC = 6'd35,
    OP_SED = 6'd36, OP_SEI = 6'd37
  } op_e;

  // status bit positions
  localparam int unsigned FLAG_C = 0;
  localparam int unsigned FLAG_Z = 1;
  localparam int unsigned FLAG_I = 2;
  localparam int unsigned FLAG_D = 3;
  localparam int unsigned FLAG_U = 5;
  localparam int unsigned FLAG_V = 6;
  localparam int unsigned FLAG_N = 7;

  localparam logic [7:0] SP_RESET    = 8'hFD;
  localparam logic [7:0] FLAGS_RESET = 8'h24;

  typedef struct packed {
    logic [7:0] acc;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] sp;
    logic [7:0] flags;
  } arch_t;

  typedef struct packed {
    logic [7:0] mem_data;
    logic       mem_write;
    logic [7:0] flags_out;
    logic [7:0] acc_out;
    logic [7:0] x_out;
    logic [7:0] y_out;
  } res_t;

endpackage

@@ design/c8alu_intf.sv @@
// valid/ready channel interfaces of the execute unit
// no dependencies
interface c8alu_in_if;
  logic       valid;
  logic       ready;
  logic [5:0] op;
  logic [7:0] operand;
  logic       on_accumulator;

  modport source (output valid, op, operand, on_accumulator, input ready);
  modport sink (input valid, op, operand, on_accumulator, output ready);
endinterface

interface c8alu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] mem_data;
  logic       mem_write;
  logic [7:0] flags_out;
  logic [7:0] acc_out;
  logic [7:0] x_out;
  logic [7:0] y_out;

  modport source (output valid, mem_data, mem_write, flags_out, acc_out, x_out, y_out,
                  input ready);
  modport sink (input valid, mem_data, mem_write, flags_out, acc_out, x_out, y_out,
                output ready);
endinterface

@@ design/c8alu_exec.sv @@
// combinational execute logic: next register state and result word
// depends on c8alu_pkg
module c8alu_exec import c8alu_pkg::*; (
  input  arch_t      st_i,
  input  logic [5:0] op_i,
  input  logic [7:0] operand_i,
  input  logic       on_acc_i,
  output arch_t      st_o,
  output res_t       res_o
);

  function automatic logic [7:0] set_nz(input logic [7:0] f, input logic [7:0] v);
    logic [7:0] r;
    r = f;
    r[FLAG_Z] = (v == 8'h00);
    r[FLAG_N] = v[7];
    return r;
  endfunction

  op_e        op;
  logic [7:0] addend;
  logic [8:0] sum;
  logic       add_v;
  logic [7:0] cmp_reg;
  logic [8:0] diff;
  logic [7:0] sh_src;
  logic [7:0] sh_res;
  logic       sh_c;
  logic [7:0] inc_m;
  logic [7:0] dec_m;
  arch_t      st;
  logic [7:0] wdata;
  logic       wen;

  assign op = op_e'(op_i);

  // sbc is adc of the inverted operand
  assign addend = (op == OP_SBC) ? ~operand_i : operand_i;
  assign sum    = {1'b0, st_i.acc} + {1'b0, addend} + {8'h00, st_i.flags[FLAG_C]};
  assign add_v  = ~(st_i.acc[7] ^ addend[7]) & (st_i.acc[7] ^ sum[7]);

  assign cmp_reg = (op == OP_CPX) ? st_i.x : ((op == OP_CPY) ? st_i.y : st_i.acc);
  assign diff    = {1'b0, cmp_reg} - {1'b0, operand_i};

  assign inc_m = operand_i + 8'd1;
  assign dec_m = operand_i - 8'd1;

  assign sh_src = on_acc_i ? st_i.acc : operand_i;

  always_comb begin
    unique case (op)
      OP_ASL: begin
        sh_res = {sh_src[6:0], 1'b0};
        sh_c   = sh_src[7];
      end
      OP_LSR: begin
        sh_res = {1'b0, sh_src[7:1]};
        sh_c   = sh_src[0];
      end
      OP_ROL: begin
        sh_res = {sh_src[6:0], st_i.flags[FLAG_C]};
        sh_c   = sh_src[7];
      end
      default: begin
        sh_res = {st_i.flags[FLAG_C], sh_src[7:1]};
        sh_c   = sh_src[0];
      end
    endcase
  end

  always_comb begin
    st    = st_i;
    wdata = 8'h00;
    wen   = 1'b0;
    unique case (op)
      OP_LDA: begin
        st.acc   = operand_i;
        st.flags = set_nz(st_i.flags, operand_i);
      end
      OP_LDX: begin
        st.x     = operand_i;
        st.flags = set_nz(st_i.flags, operand_i);
      end
      OP_LDY: begin
        st.y     = operand_i;
        st.flags = set_nz(st_i.flags, operand_i);
      end
      OP_TAX: begin
        st.x     = st_i.acc;
        st.flags = set_nz(st_i.flags, st_i.acc);
      end
      OP_TAY: begin
        st.y     = st_i.acc;
        st.flags = set_nz(st_i.flags, st_i.acc);
      end
      OP_TXA: begin
        st.acc   = st_i.x;
        st.flags = set_nz(st_i.flags, st_i.x);
      end
      OP_TYA: begin
        st.acc   = st_i.y;
        st.flags = set_nz(st_i.flags, st_i.y);
      end
      OP_TSX: begin
        st.x     = st_i.sp;
        st.flags = set_nz(st_i.flags, st_i.sp);
      end
      OP_TXS: st.sp = st_i.x;
      OP_AND: begin
        st.acc   = st_i.acc & operand_i;
        st.flags = set_nz(st_i.flags, st_i.acc & operand_i);
      end
      OP_EOR: begin
        st.acc   = st_i.acc ^ operand_i;
        st.flags = set_nz(st_i.flags, st_i.acc ^ operand_i);
      end
      OP_ORA: begin
        st.acc   = st_i.acc | operand_i;
        st.flags = set_nz(st_i.flags, st_i.acc | operand_i);
      end
      OP_BIT: begin
        st.flags[FLAG_Z] = ((st_i.acc & operand_i) == 8'h00);
        st.flags[FLAG_N] = operand_i[7];
        st.flags[FLAG_V] = operand_i[6];
      end
      OP_ADC, OP_SBC: begin
        st.acc           = sum[7:0];
        st.flags         = set_nz(st_i.flags, sum[7:0]);
        st.flags[FLAG_C] = sum[8];
        st.flags[FLAG_V] = add_v;
      end
      OP_CMP, OP_CPX, OP_CPY: begin
        st.flags[FLAG_C] = ~diff[8];
        st.flags[FLAG_Z] = (cmp_reg == operand_i);
        st.flags[FLAG_N] = diff[7];
      end
      OP_STA: begin
        wdata = st_i.acc;
        wen   = 1'b1;
      end
      OP_STX: begin
        wdata = st_i.x;
        wen   = 1'b1;
      end
      OP_STY: begin
        wdata = st_i.y;
        wen   = 1'b1;
      end
      OP_INC: begin
        wdata    = inc_m;
        wen      = 1'b1;
        st.flags = set_nz(st_i.flags, inc_m);
      end
      OP_INX: begin
        st.x     = st_i.x + 8'd1;
        st.flags = set_nz(st_i.flags, st_i.x + 8'd1);
      end
      OP_INY: begin
        st.y     = st_i.y + 8'd1;
        st.flags = set_nz(st_i.flags, st_i.y + 8'd1);
      end
      OP_DEC: begin
        wdata    = dec_m;
        wen      = 1'b1;
        st.flags = set_nz(st_i.flags, dec_m);
      end
      OP_DEX: begin
        st.x     = st_i.x - 8'd1;
        st.flags = set_nz(st_i.flags, st_i.x - 8'd1);
      end
      OP_DEY: begin
        st.y     = st_i.y - 8'd1;
        st.flags = set_nz(st_i.flags, st_i.y - 8'd1);
      end
      OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
        st.flags         = set_nz(st_i.flags, sh_res);
        st.flags[FLAG_C] = sh_c;
        if (on_acc_i) begin
          st.acc = sh_res;
        end else begin
          wdata = sh_res;
          wen   = 1'b1;
        end
      end
      OP_CLC: st.flags[FLAG_C] = 1'b0;
      OP_CLD: st.flags[FLAG_D] = 1'b0;
      OP_CLI: st.flags[FLAG_I] = 1'b0;
      OP_CLV: st.flags[FLAG_V] = 1'b0;
      OP_SEC: st.flags[FLAG_C] = 1'b1;
      OP_SED: st.flags[FLAG_D] = 1'b1;
      OP_SEI: st.flags[FLAG_I] = 1'b1;
      // unassigned codes leave everything as is
      default: ;
    endcase
  end

  assign st_o            = st;
  assign res_o.mem_data  = wdata;
  assign res_o.mem_write = wen;
  assign res_o.flags_out = st.flags;
  assign res_o.acc_out   = st.acc;
  assign res_o.x_out     = st.x;
  assign res_o.y_out     = st.y;

endmodule

@@ design/cpu8_alu_register_execute_core.sv @@
// Execute unit of an 8-bit processor in the 6502 style.
// Input channel in_i carries one word per instruction: op, operand and
// on_accumulator (selects accumulator or memory byte for shifts/rotates).
// Output channel out_o returns one word per instruction: the memory write
// byte and enable (byte is zero when no write), the status byte and the
// accumulator, X and Y after the instruction. The stack pointer is internal.
// An accepted word is held in an input register, then goes through the
// execute logic, and the register file and result register are updated
// together as it moves on into the result register. One word per cycle is
// sustained while the receiver takes results: the input register refills
// in the same cycle it hands its word over.
// When the receiver stalls, the result register holds its word and the
// input register holds one more; ready drops only when both are full.
// Reset clears A, X, Y, sets the stack pointer to 0xFD and the status byte
// to 0x24, and empties both registers.
// Decimal mode is kept as a flag only; add and subtract are binary.
// Depends on c8alu_pkg, c8alu_intf, c8alu_exec and assert_macros.svh.
`include "assert_macros.svh"
module cpu8_alu_register_execute_core import c8alu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  c8alu_in_if.sink    in_i,
  c8alu_out_if.source out_o
);

  logic       s1_valid_q;
  logic [5:0] s1_op_q;
  logic [7:0] s1_operand_q;
  logic       s1_on_acc_q;
  logic       s1_adv;
  logic       in_take;

  arch_t      st_q;
  arch_t      st_d;
  res_t       res_d;
  res_t       res_q;
  logic       out_valid_q;
  logic       out_valid_d;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_take    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_take || (s1_valid_q && !s1_adv);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_op_q      <= in_i.op;
      s1_operand_q <= in_i.operand;
      s1_on_acc_q  <= in_i.on_accumulator;
    end
  end

  c8alu_exec u_exec (
    .st_i      (st_q),
    .op_i      (s1_op_q),
    .operand_i (s1_operand_q),
    .on_acc_i  (s1_on_acc_q),
    .st_o      (st_d),
    .res_o     (res_d)
  );

  // architectural registers commit as the word moves into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.acc   <= 8'h00;
      st_q.x     <= 8'h00;
      st_q.y     <= 8'h00;
      st_q.sp    <= SP_RESET;
      st_q.flags <= FLAGS_RESET;
    end else if (s1_adv) begin
      st_q <= st_d;
    end
  end

  assign out_valid_d = s1_adv || (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.mem_data  = res_q.mem_data;
  assign out_o.mem_write = res_q.mem_write;
  assign out_o.flags_out = res_q.flags_out;
  assign out_o.acc_out   = res_q.acc_out;
  assign out_o.x_out     = res_q.x_out;
  assign out_o.y_out     = res_q.y_out;

  `C8_ASSERT(a_adv_gives_result, clk_i, rst_ni, (s1_adv |=> out_valid_q), "result missing after execute")
  `C8_ASSERT(a_no_write_zero, clk_i, rst_ni, ((out_valid_q && !res_q.mem_write) |-> (res_q.mem_data == 8'h00)), "write byte not zero without write")
  `C8_ASSERT(a_sp_only_txs, clk_i, rst_ni, ((st_q.sp != $past(st_q.sp)) |-> $past(s1_adv && (s1_op_q == OP_TXS))), "stack pointer changed without txs")
  `C8_ASSERT(a_unused_flag_set, clk_i, rst_ni, (st_q.flags[FLAG_U] == 1'b1), "unused status bit cleared")

endmodule
